[design/ptq_pkg.sv]
// shared types, constants and codes of the priority task queue
package ptq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W   = 16;
  localparam int PRIO_W = 8;
  localparam int EXEC_W = 16;
  localparam int PER_W  = 16;

  typedef enum logic {
    FUNC_ADD      = 1'b0,
    FUNC_COMPLETE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [EXEC_W-1:0] exec;
    logic [PER_W-1:0]  period;
  } slot_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_REM_HEAD,
    OP_REM_STEP,
    OP_REM_END,
    OP_INS_START,
    OP_INS_SHIFT,
    OP_INS_STOP,
    OP_HEAD_RD
  } op_e;

  typedef struct packed {
    op_e  op;
    logic set_full;
    logic set_empty;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ptr_end;
    logic ptr_zero;
    logic ptr_one;
    logic prio_lower;
    logic periodic;
  } stat_t;

endpackage

[design/ptq_datapath.sv]
// slot memory, occupancy, walk pointer and result registers
module ptq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptq_pkg::cmd_t                 cmd_i,
  output ptq_pkg::stat_t                stat_o,
  input  logic [ptq_pkg::ID_W-1:0]      task_id_i,
  input  logic [ptq_pkg::PRIO_W-1:0]    task_priority_i,
  input  logic [ptq_pkg::EXEC_W-1:0]    exec_time_i,
  input  logic [ptq_pkg::PER_W-1:0]     period_i,
  output logic [1:0]                    status_o,
  output logic [ptq_pkg::ID_W-1:0]      done_id_o,
  output logic                          requeued_o,
  output logic                          head_valid_o,
  output logic [ptq_pkg::ID_W-1:0]      head_id_o,
  output logic [ptq_pkg::PRIO_W-1:0]    head_priority_o,
  output logic [ptq_pkg::EXEC_W-1:0]    head_exec_time_o,
  output logic                          head_periodic_o,
  output logic [ptq_pkg::CNT_W-1:0]     task_count_o
);
  import ptq_pkg::*;

  slot_t mem_q [QUEUE_DEPTH];
  slot_t rdata_q;
  slot_t item_q, item_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  status_e status_q, status_d;
  logic [ID_W-1:0] done_id_q, done_id_d;
  logic req_q, req_d;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  slot_t            wdata;
  logic [CNT_W-1:0] ptr_m1, ptr_m2, ptr_p1;

  assign ptr_m1 = ptr_q - CNT_W'(1);
  assign ptr_m2 = ptr_q - CNT_W'(2);
  assign ptr_p1 = ptr_q + CNT_W'(1);

  always_comb begin
    item_d    = item_q;
    occ_d     = occ_q;
    ptr_d     = ptr_q;
    status_d  = status_q;
    done_id_d = done_id_q;
    req_d     = req_q;
    we        = 1'b0;
    waddr     = ptr_q[IDX_W-1:0];
    wdata     = rdata_q;
    re        = 1'b0;
    raddr     = '0;
    case (cmd_i.op)
      OP_LOAD: begin
        item_d    = '{id: task_id_i, prio: task_priority_i, exec: exec_time_i,
                      period: period_i};
        ptr_d     = occ_q;
        done_id_d = '0;
        req_d     = 1'b0;
        if (cmd_i.set_full) begin
          status_d = ST_FULL;
        end else if (cmd_i.set_empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d = ST_OK;
        end
        re = 1'b1;
      end
      OP_REM_HEAD: begin
        item_d    = rdata_q;
        done_id_d = rdata_q.id;
        ptr_d     = CNT_W'(1);
        re        = 1'b1;
        raddr     = IDX_W'(1);
      end
      OP_REM_STEP: begin
        // rdata holds slot ptr, move it down one place
        we    = 1'b1;
        waddr = ptr_m1[IDX_W-1:0];
        re    = 1'b1;
        raddr = ptr_p1[IDX_W-1:0];
        ptr_d = ptr_p1;
      end
      OP_REM_END: begin
        occ_d = occ_q - CNT_W'(1);
        ptr_d = occ_q - CNT_W'(1);
        req_d = item_q.period != '0;
      end
      OP_INS_START: begin
        re    = 1'b1;
        raddr = ptr_m1[IDX_W-1:0];
      end
      OP_INS_SHIFT: begin
        // rdata holds slot ptr-1, lower priority, so it moves up into the hole
        we    = 1'b1;
        re    = 1'b1;
        raddr = ptr_m2[IDX_W-1:0];
        ptr_d = ptr_m1;
      end
      OP_INS_STOP: begin
        we    = 1'b1;
        wdata = item_q;
        occ_d = occ_q + CNT_W'(1);
      end
      OP_HEAD_RD: begin
        re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    ptr_q     <= ptr_d;
    status_q  <= status_d;
    done_id_q <= done_id_d;
    req_q     <= req_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  assign stat_o.full       = occ_q == CNT_W'(QUEUE_DEPTH);
  assign stat_o.empty      = occ_q == '0;
  assign stat_o.ptr_end    = ptr_q == occ_q;
  assign stat_o.ptr_zero   = ptr_q == '0;
  assign stat_o.ptr_one    = ptr_q == CNT_W'(1);
  assign stat_o.prio_lower = rdata_q.prio < item_q.prio;
  assign stat_o.periodic   = item_q.period != '0;

  assign status_o         = status_q;
  assign done_id_o        = done_id_q;
  assign requeued_o       = req_q;
  assign head_valid_o     = occ_q != '0;
  assign head_id_o        = head_valid_o ? rdata_q.id : '0;
  assign head_priority_o  = head_valid_o ? rdata_q.prio : '0;
  assign head_exec_time_o = head_valid_o ? rdata_q.exec : '0;
  assign head_periodic_o  = head_valid_o && (rdata_q.period != '0);
  assign task_count_o     = occ_q;

endmodule

[design/ptq_ctrl.sv]
// sequencer that steps the datapath through add, complete and head readout
module ptq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           func_i,
  output logic           busy_o,
  output logic           done_o,
  output ptq_pkg::cmd_t  cmd_o,
  input  ptq_pkg::stat_t stat_i
);
  import ptq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_REM_HEAD  = 9'b000000010,
    S_REM_SHIFT = 9'b000000100,
    S_INS_START = 9'b000001000,
    S_INS_WALK  = 9'b000010000,
    S_INS_PLACE = 9'b000100000,
    S_HEAD_RD   = 9'b001000000,
    S_RESULT    = 9'b010000000,
    S_SPARE     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o.op        = OP_NONE;
    cmd_o.set_full  = 1'b0;
    cmd_o.set_empty = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          if (func_e'(func_i) == FUNC_ADD) begin
            cmd_o.set_full = stat_i.full;
            state_d = stat_i.full ? S_HEAD_RD : S_INS_START;
          end else begin
            cmd_o.set_empty = stat_i.empty;
            state_d = stat_i.empty ? S_HEAD_RD : S_REM_HEAD;
          end
        end
      end
      S_REM_HEAD: begin
        cmd_o.op = OP_REM_HEAD;
        state_d  = S_REM_SHIFT;
      end
      S_REM_SHIFT: begin
        if (stat_i.ptr_end) begin
          cmd_o.op = OP_REM_END;
          state_d  = stat_i.periodic ? S_INS_START : S_HEAD_RD;
        end else begin
          cmd_o.op = OP_REM_STEP;
        end
      end
      S_INS_START: begin
        if (stat_i.ptr_zero) begin
          cmd_o.op = OP_INS_STOP;
          state_d  = S_HEAD_RD;
        end else begin
          cmd_o.op = OP_INS_START;
          state_d  = S_INS_WALK;
        end
      end
      S_INS_WALK: begin
        // walk from the tail while the entry ahead has strictly lower priority
        if (stat_i.prio_lower) begin
          cmd_o.op = OP_INS_SHIFT;
          state_d  = stat_i.ptr_one ? S_INS_PLACE : S_INS_WALK;
        end else begin
          cmd_o.op = OP_INS_STOP;
          state_d  = S_HEAD_RD;
        end
      end
      S_INS_PLACE: begin
        cmd_o.op = OP_INS_STOP;
        state_d  = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        cmd_o.op = OP_HEAD_RD;
        state_d  = S_RESULT;
      end
      S_RESULT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_RESULT;

endmodule

[design/priority_task_queue_top.sv]
// priority task queue: top level joining the sequencer and the datapath
//
// One transaction at a time: start_i is taken when busy_o is low, and one
// result follows with done_o high for a single cycle; the receiver cannot
// stall it, so sample the result ports whenever done_o is high. A dropped add
// (queue full) or a complete on an empty queue goes straight to the head
// readout. An add moves each queued task of lower priority up one slot, then
// writes the new task into the hole. A complete shifts every remaining task
// down one slot, and a periodic task then goes back in as an add does. The
// slot memory does one registered read and one write per cycle and so moves
// one entry per cycle; busy_o drops on the cycle after done_o.
module priority_task_queue_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          func_i,
  input  logic [ptq_pkg::ID_W-1:0]      task_id_i,
  input  logic [ptq_pkg::PRIO_W-1:0]    task_priority_i,
  input  logic [ptq_pkg::EXEC_W-1:0]    exec_time_i,
  input  logic [ptq_pkg::PER_W-1:0]     period_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [ptq_pkg::ID_W-1:0]      done_id_o,
  output logic                          requeued_o,
  output logic                          head_valid_o,
  output logic [ptq_pkg::ID_W-1:0]      head_id_o,
  output logic [ptq_pkg::PRIO_W-1:0]    head_priority_o,
  output logic [ptq_pkg::EXEC_W-1:0]    head_exec_time_o,
  output logic                          head_periodic_o,
  output logic [ptq_pkg::CNT_W-1:0]     task_count_o
);
  import ptq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ptq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  ptq_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .task_id_i        (task_id_i),
    .task_priority_i  (task_priority_i),
    .exec_time_i      (exec_time_i),
    .period_i         (period_i),
    .status_o         (status_o),
    .done_id_o        (done_id_o),
    .requeued_o       (requeued_o),
    .head_valid_o     (head_valid_o),
    .head_id_o        (head_id_o),
    .head_priority_o  (head_priority_o),
    .head_exec_time_o (head_exec_time_o),
    .head_periodic_o  (head_periodic_o),
    .task_count_o     (task_count_o)
  );

endmodule

[design/ptq_checker.sv]
// port-level checks on the priority task queue, bound to the top level
module ptq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       done_o,
  input logic [1:0]                 status_o,
  input logic [ptq_pkg::ID_W-1:0]   done_id_o,
  input logic                       requeued_o,
  input logic                       head_valid_o,
  input logic [ptq_pkg::CNT_W-1:0]  task_count_o
);
  import ptq_pkg::*;

  // an accepted transaction keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted transaction did not raise busy");

  // the result strobe lasts one cycle and the block is free right after it
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_head_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> head_valid_o == (task_count_o != '0))
    else $error("head valid disagrees with task count");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_EMPTY |->
      task_count_o == '0 && done_id_o == '0 && !requeued_o)
    else $error("empty complete changed the queue");

  a_requeue_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && requeued_o |-> status_o == ST_OK && head_valid_o)
    else $error("requeued task missing from queue");

endmodule

bind priority_task_queue_top ptq_checker u_ptq_checker (.*);

[tb/priority_task_queue_top_test.sv]
// testbench for the priority task queue: directed and random transactions, scored by a predictor
`timescale 1ns / 1ps

module priority_task_queue_top_test;
  import ptq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_WAIT  = 60;
  localparam int unsigned PHASE_ITEMS  = 48;
  localparam int unsigned PHASE_COUNT  = 12;

  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     done_id;
    logic                requeued;
    logic                head_valid;
    logic [ID_W-1:0]     head_id;
    logic [PRIO_W-1:0]   head_priority;
    logic [EXEC_W-1:0]   head_exec_time;
    logic                head_periodic;
    logic [CNT_W-1:0]    task_count;
  } sched_res_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                start_i         = 1'b0;
  logic                func_i          = FUNC_ADD;
  logic [ID_W-1:0]     task_id_i       = '0;
  logic [PRIO_W-1:0]   task_priority_i = '0;
  logic [EXEC_W-1:0]   exec_time_i     = '0;
  logic [PER_W-1:0]    period_i        = '0;
  logic                busy_o;
  logic                done_o;
  logic [1:0]          status_o;
  logic [ID_W-1:0]     done_id_o;
  logic                requeued_o;
  logic                head_valid_o;
  logic [ID_W-1:0]     head_id_o;
  logic [PRIO_W-1:0]   head_priority_o;
  logic [EXEC_W-1:0]   head_exec_time_o;
  logic                head_periodic_o;
  logic [CNT_W-1:0]    task_count_o;

  slot_t       sched_q[$];    // predicted queue contents, head first
  sched_res_t  outcome_q[$];  // predicted results not yet seen
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  bit          calm       = 1'b0;

  priority_task_queue_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .func_i           (func_i),
    .task_id_i        (task_id_i),
    .task_priority_i  (task_priority_i),
    .exec_time_i      (exec_time_i),
    .period_i         (period_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .done_id_o        (done_id_o),
    .requeued_o       (requeued_o),
    .head_valid_o     (head_valid_o),
    .head_id_o        (head_id_o),
    .head_priority_o  (head_priority_o),
    .head_exec_time_o (head_exec_time_o),
    .head_periodic_o  (head_periodic_o),
    .task_count_o     (task_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // new task goes behind every queued task of equal or higher priority
  function automatic void place_slot(slot_t s);
    int pos;
    pos = 0;
    while (pos < sched_q.size() && sched_q[pos].prio >= s.prio) pos++;
    sched_q.insert(pos, s);
  endfunction

  function automatic sched_res_t schedule_outcome(func_e f, slot_t s);
    sched_res_t r;
    slot_t      h;
    r = '0;
    r.status = ST_OK;
    if (f == FUNC_ADD) begin
      if (sched_q.size() >= QUEUE_DEPTH) r.status = ST_FULL;
      else place_slot(s);
    end else if (sched_q.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      h = sched_q.pop_front();
      r.done_id = h.id;
      if (h.period != 0) begin
        place_slot(h);
        r.requeued = 1'b1;
      end
    end
    if (sched_q.size() > 0) begin
      r.head_valid     = 1'b1;
      r.head_id        = sched_q[0].id;
      r.head_priority  = sched_q[0].prio;
      r.head_exec_time = sched_q[0].exec;
      r.head_periodic  = (sched_q[0].period != 0);
    end
    r.task_count = CNT_W'(sched_q.size());
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    sched_res_t want;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        $error("result transaction with no transaction outstanding");
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", want.status, status_o);
        check_field("done_id", want.done_id, done_id_o);
        check_field("requeued", want.requeued, requeued_o);
        check_field("head_valid", want.head_valid, head_valid_o);
        check_field("head_id", want.head_id, head_id_o);
        check_field("head_priority", want.head_priority, head_priority_o);
        check_field("head_exec_time", want.head_exec_time, head_exec_time_o);
        check_field("head_periodic", want.head_periodic, head_periodic_o);
        check_field("task_count", want.task_count, task_count_o);
      end
    end
  end

  // start_i stays high from one transaction to the next unless a gap is taken
  task automatic send_item(func_e f, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                           logic [EXEC_W-1:0] exec, logic [PER_W-1:0] per);
    slot_t s;
    int unsigned gap;
    s = '{id: id, prio: prio, exec: exec, period: per};
    if (!calm && $urandom_range(99) < 7) begin
      start_i <= 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    func_i          <= f;
    task_id_i       <= id;
    task_priority_i <= prio;
    exec_time_i     <= exec;
    period_i        <= per;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    outcome_q.push_back(schedule_outcome(f, s));
  endtask

  task automatic complete_head();
    send_item(FUNC_COMPLETE, ID_W'($urandom_range(16'hffff)),
              PRIO_W'($urandom_range(8'hff)), EXEC_W'($urandom_range(16'hffff)),
              PER_W'($urandom_range(16'hffff)));
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_complete();
    complete_head();
  endtask

  task automatic test_order_and_requeue();
    send_item(FUNC_ADD, 16'hffff, 8'hff, 16'hffff, 16'hffff);
    // lowest priority must not take the head
    send_item(FUNC_ADD, 16'h0001, 8'h00, 16'h0000, 16'h0000);
    send_item(FUNC_ADD, 16'h0002, 8'hff, 16'h0001, 16'h0000);
    send_item(FUNC_ADD, 16'h0000, 8'h80, 16'h8000, 16'h0000);
    // periodic head goes back in behind its equal-priority peer
    complete_head();
    complete_head();
    complete_head();
  endtask

  task automatic test_full_queue();
    int unsigned i;
    i = 0;
    while (sched_q.size() < QUEUE_DEPTH) begin
      send_item(FUNC_ADD, 16'(16'h1000 + i), 8'((i * 13) & 8'hff), 16'(i * 4099),
                (i % 5 == 0) ? 16'h0001 : 16'h0000);
      i++;
    end
    send_item(FUNC_ADD, 16'h5555, 8'haa, 16'h5555, 16'haaaa);
    // periodic head on a full queue is removed before it goes back in
    complete_head();
  endtask

  task automatic test_random_traffic();
    int unsigned add_pct;
    logic [PRIO_W-1:0] prio;
    logic [PER_W-1:0]  per;
    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      case (p % 4)
        0: add_pct = 80;
        1: add_pct = 30;
        2: add_pct = 55;
        default: add_pct = 10;
      endcase
      calm = (p == 5);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < add_pct) begin
          case ($urandom_range(2))
            0: prio = PRIO_W'($urandom_range(3));
            1: prio = PRIO_W'($urandom_range(8'hff));
            default: prio = $urandom_range(1) ? 8'hff : 8'h00;
          endcase
          // periodic tasks never leave, keep them rare
          if ($urandom_range(99) < 4)
            per = $urandom_range(1) ? 16'hffff : PER_W'($urandom_range(16'hffff, 1));
          else per = '0;
          send_item(FUNC_ADD, ID_W'($urandom_range(16'hffff)), prio,
                    EXEC_W'($urandom_range(16'hffff)), per);
        end else begin
          complete_head();
        end
      end
      if (p % 3 == 1) drain_results();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_complete();
    test_order_and_requeue();
    test_full_queue();
    drain_results();
    test_random_traffic();
    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ptq_pkg.sv
design/ptq_datapath.sv
design/ptq_ctrl.sv
design/priority_task_queue_top.sv
design/ptq_checker.sv
tb/priority_task_queue_top_test.sv
